// File: rtl/nhms_pkg.sv
// ----------------------------------------------------------------------------
// nhms_pkg
// Shared types, codes and saturating helpers of the network heat mixing step.
// ----------------------------------------------------------------------------
package nhms_pkg;

  localparam int NODE_COUNT_DEF = 16;
  localparam int LINK_COUNT_DEF = 32;

  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0001;
  localparam logic [63:0]        HI_LIMIT = 64'h0000_8000_0000_0000;
  localparam logic [49:0]        D_LIMIT  = 50'h0_0000_8000_0000;

  typedef enum logic [2:0] {
    OP_LOAD_NODE  = 3'd0,
    OP_LOAD_LINK  = 3'd1,
    OP_RUN        = 3'd2,
    OP_READ_NODE  = 3'd3,
    OP_READ_LINK  = 3'd4,
    OP_WRITE_NODE = 3'd5,
    OP_WRITE_LINK = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_SKIP  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CFG_ENABLE    = 2'd0,
    CFG_STEADY    = 2'd1,
    CFG_INIT_TEMP = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic signed [31:0] temp;
    logic [31:0]        v_old;
    logic [31:0]        v_in;
    logic signed [31:0] ext;
    logic signed [63:0] heat;
  } node_ent_t;

  typedef struct packed {
    logic signed [31:0] temp;
    logic signed [31:0] flow;
    logic [4:0]         from_n;
    logic [4:0]         to_n;
    logic [31:0]        v_old;
    logic [31:0]        v_new;
  } link_ent_t;

  typedef struct packed {
    logic               start;
    logic signed [63:0] dividend;
    logic [32:0]        divisor;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic signed [63:0] quotient;
  } div_resp_t;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = $signed({a[63], a}) + $signed({b[63], b});
    if (s > $signed({1'b0, S64_MAX})) begin
      return S64_MAX;
    end else if (s < $signed({1'b1, S64_MIN})) begin
      return S64_MIN;
    end
    return s[63:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (v < 64'shFFFF_FFFF_8000_0000) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

// File: rtl/network_heat_mixing_step.sv
// Loads and temperature writes: the result is registered in the cycle after the word is
// taken, one word per cycle while the output is not stalled. Reads: the memory read is
// registered, then the result; no new word is taken until it is out. Run: nodes and
// links share the 64-step divider; no other word is taken until the run's result is out.
// Reset clears control; temperatures read as zero until written, with no clearing pass.
// ----------------------------------------------------------------------------
// network_heat_mixing_step
// Node and link temperature store of a drainage network with a sequencer that
// advances all temperatures by one routing step.
// ----------------------------------------------------------------------------
module network_heat_mixing_step import nhms_pkg::*; #(
  parameter int NODE_COUNT = NODE_COUNT_DEF,
  parameter int LINK_COUNT = LINK_COUNT_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         operation_i,
  input  logic [4:0]         index_i,
  input  logic [31:0]        old_volume_i,
  input  logic [31:0]        inflow_volume_i,
  input  logic [31:0]        new_volume_i,
  input  logic signed [31:0] external_rate_i,
  input  logic signed [31:0] flow_i,
  input  logic [4:0]         from_node_i,
  input  logic [4:0]         to_node_i,
  input  logic [31:0]        time_step_i,
  input  logic signed [31:0] temperature_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] temperature_out_o,
  output logic [1:0]         status_o
);

  localparam int NAW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int LAW = (LINK_COUNT > 1) ? $clog2(LINK_COUNT) : 1;

  typedef enum logic [22:0] {
    S_IDLE = 23'h000001,
    S_RESP = 23'h000002,
    S_HL   = 23'h000004,
    S_HN   = 23'h000008,
    S_HA   = 23'h000010,
    S_NR   = 23'h000020,
    S_NA   = 23'h000040,
    S_NM1  = 23'h000080,
    S_NM2  = 23'h000100,
    S_NM3  = 23'h000200,
    S_NDS  = 23'h000400,
    S_NDW  = 23'h000800,
    S_NP   = 23'h001000,
    S_NQ   = 23'h002000,
    S_NDW2 = 23'h004000,
    S_LL   = 23'h008000,
    S_LU   = 23'h010000,
    S_LN   = 23'h020000,
    S_LW   = 23'h040000,
    S_LS   = 23'h080000,
    S_LM   = 23'h100000,
    S_LDS  = 23'h200000,
    S_LDW  = 23'h400000
  } state_e;

  state_e state_q, state_d;
  logic [NAW-1:0] nidx_q, nidx_d;
  logic [LAW-1:0] lidx_q, lidx_d;

  logic               enable_q;
  logic               steady_q;
  logic signed [31:0] init_q;
  logic               seeded_q;
  logic               seeding_q;

  node_ent_t node_mem [NODE_COUNT];
  link_ent_t link_mem [LINK_COUNT];
  node_ent_t nrd_q;
  link_ent_t lrd_q;
  logic [NODE_COUNT-1:0] node_tv_q;
  logic [NODE_COUNT-1:0] heat_v_q;
  logic [LINK_COUNT-1:0] link_tv_q;
  logic ntv_rd_q, hv_rd_q, ltv_rd_q;

  logic               out_valid_q;
  logic signed [31:0] out_temp_q;
  logic [1:0]         out_status_q;

  logic               rd_link_q;
  logic [31:0]        dt_q;
  logic [NAW-1:0]     down_q;
  logic signed [63:0] prod_q;
  logic signed [63:0] heat_q;
  logic signed [31:0] told_q;
  logic [31:0]        vold_q;
  logic [31:0]        vin_q;
  logic [63:0]        lo_q;
  logic [63:0]        hi_q;
  logic signed [63:0] m_q;
  logic signed [31:0] tin_q;
  logic signed [31:0] lflow_q;
  logic [31:0]        lvo_q;
  logic [31:0]        lvn_q;
  logic signed [31:0] tup_q;
  logic [63:0]        qd_q;
  logic [49:0]        w_q;
  logic [31:0]        vo_q;
  logic [30:0]        d_q;

  logic in_fire;
  logic node_ok, link_ok;
  op_e  op;

  logic [NAW-1:0]     nra, nw_addr;
  logic [LAW-1:0]     lra, lw_addr;
  logic               nw_temp_en, nw_load_en, nw_heat_en;
  logic signed [31:0] nw_temp;
  logic signed [63:0] nw_heat;
  logic               lw_temp_en, lw_load_en;
  logic signed [31:0] lw_temp;
  logic               out_load;
  logic signed [31:0] out_temp;
  status_e            out_status;
  logic               run_start, run_end;
  div_req_t           div_req;
  div_resp_t          div_resp;

  logic signed [31:0] hf;
  logic [4:0]         hdown;
  logic [31:0]        fmag;
  logic signed [64:0] hprod;
  logic signed [31:0] lt_old_sel;
  logic signed [31:0] nt_old_sel;
  logic signed [63:0] ext_scaled;
  logic [63:0]        hmag;
  logic [64:0]        rsum;
  logic [63:0]        rval;
  logic signed [64:0] nprod;
  logic signed [31:0] tnew;
  logic signed [31:0] clamp_lo, clamp_hi;
  logic [4:0]         lup;
  logic signed [31:0] tup_sel;
  logic [31:0]        qmag;
  logic [31:0]        growth;
  logic [49:0]        wsum;
  logic [49:0]        dsum;
  logic signed [32:0] diff;
  logic signed [64:0] lprod;
  logic signed [63:0] lsum;

  assign op      = op_e'(operation_i);
  assign node_ok = 32'(index_i) < NODE_COUNT;
  assign link_ok = 32'(index_i) < LINK_COUNT;

  assign in_ready_o  = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  assign lt_old_sel = seeding_q ? init_q : (ltv_rd_q ? lrd_q.temp : 32'sd0);
  assign nt_old_sel = seeding_q ? init_q : (ntv_rd_q ? nrd_q.temp : 32'sd0);

  assign hf    = lrd_q.flow;
  assign hdown = hf[31] ? lrd_q.from_n : lrd_q.to_n;
  assign fmag  = hf[31] ? 32'(-hf) : 32'(hf);
  assign hprod = $signed({1'b0, fmag}) * lt_old_sel;

  assign ext_scaled = {{16{nrd_q.ext[31]}}, nrd_q.ext, 16'b0};
  assign hmag       = heat_q[63] ? 64'(-heat_q) : 64'(heat_q);
  assign rsum       = {1'b0, hi_q[47:0], 16'b0} + {17'b0, lo_q[63:16]};
  assign rval       = ((hi_q >= HI_LIMIT) || (rsum > {1'b0, S64_MAX})) ? S64_MAX : rsum[63:0];
  assign nprod      = told_q * $signed({1'b0, vold_q});
  assign tnew       = sat32(div_resp.quotient);
  assign clamp_lo   = (told_q < tin_q) ? told_q : tin_q;
  assign clamp_hi   = (told_q < tin_q) ? tin_q : told_q;

  assign lup     = hf[31] ? lrd_q.to_n : lrd_q.from_n;
  assign tup_sel = ntv_rd_q ? nrd_q.temp : 32'sd0;
  assign qmag    = lflow_q[31] ? 32'(-lflow_q) : 32'(lflow_q);
  assign growth  = (lvn_q > lvo_q) ? (lvn_q - lvo_q) : 32'd0;
  assign wsum    = {2'b0, qd_q[63:16]} + {18'b0, growth};
  assign dsum    = {18'b0, vo_q} + w_q;
  assign diff    = $signed({tup_q[31], tup_q}) - $signed({told_q[31], told_q});
  assign lprod   = diff * $signed({1'b0, w_q[30:0]});
  assign lsum    = {{32{told_q[31]}}, told_q} + div_resp.quotient;

  always_comb begin
    state_d    = state_q;
    nidx_d     = nidx_q;
    lidx_d     = lidx_q;
    nra        = nidx_q;
    lra        = lidx_q;
    nw_addr    = nidx_q;
    lw_addr    = lidx_q;
    nw_temp_en = 1'b0;
    nw_load_en = 1'b0;
    nw_heat_en = 1'b0;
    nw_temp    = '0;
    nw_heat    = '0;
    lw_temp_en = 1'b0;
    lw_load_en = 1'b0;
    lw_temp    = '0;
    out_load   = 1'b0;
    out_temp   = '0;
    out_status = ST_OK;
    run_start  = 1'b0;
    run_end    = 1'b0;
    div_req    = '0;
    case (state_q)
      S_IDLE: begin
        nra     = NAW'(index_i);
        lra     = LAW'(index_i);
        nw_addr = NAW'(index_i);
        lw_addr = LAW'(index_i);
        if (in_fire) begin
          out_load = 1'b1;
          case (op)
            OP_LOAD_NODE: begin
              if (node_ok) nw_load_en = 1'b1;
              else out_status = ST_RANGE;
            end
            OP_LOAD_LINK: begin
              if (link_ok) lw_load_en = 1'b1;
              else out_status = ST_RANGE;
            end
            OP_RUN: begin
              if (!enable_q || time_step_i == 32'd0) begin
                out_status = ST_SKIP;
              end else begin
                out_load  = 1'b0;
                run_start = 1'b1;
                lidx_d    = '0;
                nidx_d    = '0;
                state_d   = S_HL;
              end
            end
            OP_READ_NODE: begin
              if (node_ok) begin
                out_load = 1'b0;
                state_d  = S_RESP;
              end else begin
                out_status = ST_RANGE;
              end
            end
            OP_READ_LINK: begin
              if (link_ok) begin
                out_load = 1'b0;
                state_d  = S_RESP;
              end else begin
                out_status = ST_RANGE;
              end
            end
            OP_WRITE_NODE: begin
              if (node_ok) begin
                nw_temp_en = 1'b1;
                nw_temp    = temperature_i;
              end else begin
                out_status = ST_RANGE;
              end
            end
            OP_WRITE_LINK: begin
              if (link_ok) begin
                lw_temp_en = 1'b1;
                lw_temp    = temperature_i;
              end else begin
                out_status = ST_RANGE;
              end
            end
            default: out_status = ST_RANGE;
          endcase
        end
      end
      S_RESP: begin
        out_load = 1'b1;
        if (rd_link_q) out_temp = ltv_rd_q ? lrd_q.temp : 32'sd0;
        else out_temp = ntv_rd_q ? nrd_q.temp : 32'sd0;
        state_d = S_IDLE;
      end
      S_HL: begin
        state_d = S_HN;
      end
      S_HN: begin
        nra = NAW'(hdown);
        if (hf == 32'sd0 || !(32'(hdown) < NODE_COUNT)) begin
          if (lidx_q == LAW'(LINK_COUNT - 1)) begin
            lidx_d  = '0;
            state_d = S_NR;
          end else begin
            lidx_d  = lidx_q + 1'b1;
            state_d = S_HL;
          end
        end else begin
          state_d = S_HA;
        end
      end
      S_HA: begin
        nw_addr    = down_q;
        nw_heat_en = 1'b1;
        nw_heat    = sat_add(hv_rd_q ? nrd_q.heat : 64'sd0, prod_q);
        if (lidx_q == LAW'(LINK_COUNT - 1)) begin
          lidx_d  = '0;
          state_d = S_NR;
        end else begin
          lidx_d  = lidx_q + 1'b1;
          state_d = S_HL;
        end
      end
      S_NR: begin
        state_d = S_NA;
      end
      S_NA: begin
        if (nrd_q.v_in == 32'd0) begin
          nw_temp_en = 1'b1;
          nw_temp    = nt_old_sel;
          if (nidx_q == NAW'(NODE_COUNT - 1)) begin
            lidx_d  = '0;
            state_d = S_LL;
          end else begin
            nidx_d  = nidx_q + 1'b1;
            state_d = S_NR;
          end
        end else begin
          state_d = S_NM1;
        end
      end
      S_NM1: state_d = S_NM2;
      S_NM2: state_d = S_NM3;
      S_NM3: state_d = S_NDS;
      S_NDS: begin
        div_req.start    = 1'b1;
        div_req.dividend = m_q;
        div_req.divisor  = {1'b0, vin_q};
        state_d          = S_NDW;
      end
      S_NDW: begin
        if (div_resp.done) state_d = S_NP;
      end
      S_NP: state_d = S_NQ;
      S_NQ: begin
        if (vold_q == 32'd0) begin
          nw_temp_en = 1'b1;
          nw_temp    = tin_q;
          if (nidx_q == NAW'(NODE_COUNT - 1)) begin
            lidx_d  = '0;
            state_d = S_LL;
          end else begin
            nidx_d  = nidx_q + 1'b1;
            state_d = S_NR;
          end
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = sat_add(prod_q, m_q);
          div_req.divisor  = {1'b0, vold_q} + {1'b0, vin_q};
          state_d          = S_NDW2;
        end
      end
      S_NDW2: begin
        if (div_resp.done) begin
          nw_temp_en = 1'b1;
          if (tnew < clamp_lo) nw_temp = clamp_lo;
          else if (tnew > clamp_hi) nw_temp = clamp_hi;
          else nw_temp = tnew;
          if (nidx_q == NAW'(NODE_COUNT - 1)) begin
            lidx_d  = '0;
            state_d = S_LL;
          end else begin
            nidx_d  = nidx_q + 1'b1;
            state_d = S_NR;
          end
        end
      end
      S_LL: state_d = S_LU;
      S_LU: begin
        nra = NAW'(lup);
        if (!(32'(lup) < NODE_COUNT)) begin
          lw_temp_en = 1'b1;
          lw_temp    = lt_old_sel;
          if (lidx_q == LAW'(LINK_COUNT - 1)) begin
            run_end  = 1'b1;
            out_load = 1'b1;
            state_d  = S_IDLE;
          end else begin
            lidx_d  = lidx_q + 1'b1;
            state_d = S_LL;
          end
        end else begin
          state_d = S_LN;
        end
      end
      S_LN: begin
        if (steady_q || (lflow_q != 32'sd0 && lvn_q == 32'd0) || lflow_q == 32'sd0) begin
          lw_temp_en = 1'b1;
          lw_temp    = (lflow_q == 32'sd0 && !steady_q) ? told_q : tup_sel;
          if (lidx_q == LAW'(LINK_COUNT - 1)) begin
            run_end  = 1'b1;
            out_load = 1'b1;
            state_d  = S_IDLE;
          end else begin
            lidx_d  = lidx_q + 1'b1;
            state_d = S_LL;
          end
        end else begin
          state_d = S_LW;
        end
      end
      S_LW: state_d = S_LS;
      S_LS: begin
        if (dsum == 50'd0) begin
          lw_temp_en = 1'b1;
          lw_temp    = tup_q;
          if (lidx_q == LAW'(LINK_COUNT - 1)) begin
            run_end  = 1'b1;
            out_load = 1'b1;
            state_d  = S_IDLE;
          end else begin
            lidx_d  = lidx_q + 1'b1;
            state_d = S_LL;
          end
        end else if (dsum < D_LIMIT) begin
          state_d = S_LM;
        end
      end
      S_LM: state_d = S_LDS;
      S_LDS: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod_q;
        div_req.divisor  = {2'b0, d_q};
        state_d          = S_LDW;
      end
      S_LDW: begin
        if (div_resp.done) begin
          lw_temp_en = 1'b1;
          lw_temp    = sat32(lsum);
          if (lidx_q == LAW'(LINK_COUNT - 1)) begin
            run_end  = 1'b1;
            out_load = 1'b1;
            state_d  = S_IDLE;
          end else begin
            lidx_d  = lidx_q + 1'b1;
            state_d = S_LL;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      nidx_q      <= '0;
      lidx_q      <= '0;
      enable_q    <= 1'b0;
      steady_q    <= 1'b0;
      init_q      <= '0;
      seeded_q    <= 1'b0;
      seeding_q   <= 1'b0;
      node_tv_q   <= '0;
      heat_v_q    <= '0;
      link_tv_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      nidx_q  <= nidx_d;
      lidx_q  <= lidx_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_ENABLE:    enable_q <= cfg_data_i[0];
          CFG_STEADY:    steady_q <= cfg_data_i[0];
          CFG_INIT_TEMP: init_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (run_start) begin
        seeding_q <= !seeded_q;
        heat_v_q  <= '0;
      end
      if (run_end) seeded_q <= 1'b1;
      if (nw_temp_en) node_tv_q[nw_addr] <= 1'b1;
      if (nw_heat_en) heat_v_q[nw_addr] <= 1'b1;
      if (lw_temp_en) link_tv_q[lw_addr] <= 1'b1;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (nw_temp_en) node_mem[nw_addr].temp <= nw_temp;
    if (nw_load_en) begin
      node_mem[nw_addr].v_old <= old_volume_i;
      node_mem[nw_addr].v_in  <= inflow_volume_i;
      node_mem[nw_addr].ext   <= external_rate_i;
    end
    if (nw_heat_en) node_mem[nw_addr].heat <= nw_heat;
    nrd_q    <= node_mem[nra];
    ntv_rd_q <= node_tv_q[nra];
    hv_rd_q  <= heat_v_q[nra];
  end

  always_ff @(posedge clk_i) begin
    if (lw_temp_en) link_mem[lw_addr].temp <= lw_temp;
    if (lw_load_en) begin
      link_mem[lw_addr].flow   <= flow_i;
      link_mem[lw_addr].from_n <= from_node_i;
      link_mem[lw_addr].to_n   <= to_node_i;
      link_mem[lw_addr].v_old  <= old_volume_i;
      link_mem[lw_addr].v_new  <= new_volume_i;
    end
    lrd_q    <= link_mem[lra];
    ltv_rd_q <= link_tv_q[lra];
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_temp_q   <= out_temp;
      out_status_q <= out_status;
    end
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          rd_link_q <= (op == OP_READ_LINK);
          dt_q      <= time_step_i;
        end
      end
      S_HN: begin
        down_q <= NAW'(hdown);
        prod_q <= hprod[63:0];
      end
      S_NA: begin
        heat_q <= sat_add(hv_rd_q ? nrd_q.heat : 64'sd0, ext_scaled);
        told_q <= nt_old_sel;
        vold_q <= nrd_q.v_old;
        vin_q  <= nrd_q.v_in;
      end
      S_NM1: lo_q <= hmag[31:0] * dt_q;
      S_NM2: hi_q <= hmag[62:32] * dt_q;
      S_NM3: m_q  <= heat_q[63] ? -$signed(rval) : $signed(rval);
      S_NDW: begin
        if (div_resp.done) tin_q <= tnew;
      end
      S_NP: prod_q <= nprod[63:0];
      S_LU: begin
        lflow_q <= lrd_q.flow;
        lvo_q   <= lrd_q.v_old;
        lvn_q   <= lrd_q.v_new;
        told_q  <= lt_old_sel;
      end
      S_LN: begin
        tup_q <= tup_sel;
        qd_q  <= qmag * dt_q;
      end
      S_LW: begin
        w_q  <= wsum;
        vo_q <= lvo_q;
      end
      S_LS: begin
        if (dsum >= D_LIMIT) begin
          vo_q <= vo_q >> 1;
          w_q  <= w_q >> 1;
        end
        d_q <= dsum[30:0];
      end
      S_LM: prod_q <= lprod[63:0];
      default: ;
    endcase
  end

  nhms_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .resp_o (div_resp)
  );

  assign out_valid_o       = out_valid_q;
  assign temperature_out_o = out_temp_q;
  assign status_o          = out_status_q;

`ifndef SYNTHESIS
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_resp.busy)
    else $error("Divider started while busy.");

  a_no_word_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !out_valid_q)
    else $error("Result word pending while a read or run is in progress.");

  a_skip_no_temp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_SKIP) |-> (temperature_out_o == 32'sd0))
    else $error("Skipped run returned a nonzero temperature.");

  a_seeded_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(seeded_q))
    else $error("Seed flag cleared outside reset.");

  a_seed_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_start && seeded_q) |=> !seeding_q)
    else $error("Seed applied on a later run.");
`endif

endmodule

// File: rtl/nhms_div.sv
// ----------------------------------------------------------------------------
// nhms_div
// Signed by unsigned restoring divider, one quotient bit per cycle,
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
module nhms_div import nhms_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  div_req_t  req_i,
  output div_resp_t resp_o
);

  logic        busy_q;
  logic        done_q;
  logic [5:0]  cnt_q;
  logic [63:0] num_q;
  logic [32:0] rem_q;
  logic [32:0] dvs_q;
  logic [63:0] quo_q;
  logic        neg_q;
  logic [33:0] rsh;
  logic        qbit;

  assign rsh  = {rem_q, num_q[63]};
  assign qbit = rsh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      num_q <= req_i.dividend[63] ? -req_i.dividend : req_i.dividend;
      neg_q <= req_i.dividend[63];
      dvs_q <= req_i.divisor;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[62:0], 1'b0};
      quo_q <= {quo_q[62:0], qbit};
      rem_q <= qbit ? 33'(rsh - {1'b0, dvs_q}) : rsh[32:0];
    end
  end

  assign resp_o.busy     = busy_q;
  assign resp_o.done     = done_q;
  assign resp_o.quotient = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

// File: tb/tb_network_heat_mixing_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_network_heat_mixing_step
// Drives load, run, read and write words into the heat mixing step under
// random gaps and output stalls, predicts every result with a behavioral
// copy of the node and link temperature update, and checks each result word.
// ----------------------------------------------------------------------------
module tb_network_heat_mixing_step;
  import nhms_pkg::*;

  localparam int NODES = 16;
  localparam int LINKS = 32;
  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam longint S64_TOP = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam int WATCHDOG_LIMIT = 40000;

  typedef struct {
    logic [2:0]         op;
    logic [4:0]         idx;
    logic [31:0]        v_old;
    logic [31:0]        v_in;
    logic [31:0]        v_new;
    logic signed [31:0] rate;
    logic signed [31:0] flow;
    logic [4:0]         from_n;
    logic [4:0]         to_n;
    logic [31:0]        dt;
    logic signed [31:0] temp;
  } heat_word_t;

  typedef struct {
    logic signed [31:0] temp;
    logic [1:0]         status;
  } heat_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i = '0;
  logic [31:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [2:0]         operation_i = '0;
  logic [4:0]         index_i = '0;
  logic [31:0]        old_volume_i = '0;
  logic [31:0]        inflow_volume_i = '0;
  logic [31:0]        new_volume_i = '0;
  logic signed [31:0] external_rate_i = '0;
  logic signed [31:0] flow_i = '0;
  logic [4:0]         from_node_i = '0;
  logic [4:0]         to_node_i = '0;
  logic [31:0]        time_step_i = '0;
  logic signed [31:0] temperature_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [31:0] temperature_out_o;
  logic [1:0]         status_o;

  network_heat_mixing_step dut (.*);

  always #5 clk_i = ~clk_i;

  // Predicted block state.
  logic               m_enable, m_steady, m_seeded;
  logic signed [31:0] m_init;
  logic signed [31:0] node_t [NODES];
  logic signed [31:0] link_t [LINKS];
  logic [31:0]        nv_old [NODES];
  logic [31:0]        nv_in [NODES];
  logic signed [31:0] n_rate [NODES];
  logic signed [31:0] l_flow [LINKS];
  logic [4:0]         l_from [LINKS];
  logic [4:0]         l_to [LINKS];
  logic [31:0]        lv_old [LINKS];
  logic [31:0]        lv_new [LINKS];

  heat_word_t   pending_words[$];
  heat_result_t expected_results[$];
  heat_word_t   cur_word;
  int           errors = 0;

  function automatic longint add_sat(longint a, longint b);
    if (b > 0 && a > S64_TOP - b) return S64_TOP;
    if (b < 0 && a < -S64_TOP - b) return -S64_TOP;
    return a + b;
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return -64'sh8000_0000;
    return v;
  endfunction

  function automatic longint scale_dt(longint h, logic [31:0] dt);
    logic [63:0] mag, lo, hi, r;
    logic neg;
    neg = h < 0;
    mag = neg ? -h : h;
    lo = {32'h0, mag[31:0]} * {32'h0, dt};
    hi = {32'h0, mag[63:32]} * {32'h0, dt};
    if (hi >= 64'h0000_8000_0000_0000) begin
      r = S64_TOP;
    end else begin
      r = (hi << 16) + (lo >> 16);
      if (r > S64_TOP) r = S64_TOP;
    end
    return neg ? -longint'(r) : longint'(r);
  endfunction

  function automatic void mix_step(logic [31:0] dt_bits);
    longint heat [NODES];
    longint snap_l [LINKS];
    longint dt, f, t_old, vo, vi, vn, m, t_in, t_new, lo_b, hi_b, q, w, d, t_up;
    int dn, up;
    dt = longint'(dt_bits);
    if (!m_seeded) begin
      foreach (node_t[i]) node_t[i] = m_init;
      foreach (link_t[j]) link_t[j] = m_init;
      m_seeded = 1'b1;
    end
    foreach (heat[i]) heat[i] = 0;
    foreach (snap_l[j]) snap_l[j] = link_t[j];
    for (int j = 0; j < LINKS; j++) begin
      f = l_flow[j];
      if (f != 0) begin
        dn = (f > 0) ? l_to[j] : l_from[j];
        if (dn < NODES) heat[dn] = add_sat(heat[dn], (f < 0 ? -f : f) * snap_l[j]);
      end
    end
    for (int i = 0; i < NODES; i++) begin
      t_old = node_t[i];
      vo = longint'(nv_old[i]);
      vi = longint'(nv_in[i]);
      heat[i] = add_sat(heat[i], longint'(n_rate[i]) * 65536);
      if (vi != 0) begin
        m = scale_dt(heat[i], dt_bits);
        t_in = clip32(m / vi);
        if (vo != 0) t_new = clip32(add_sat(t_old * vo, m) / (vo + vi));
        else t_new = t_in;
        lo_b = t_old < t_in ? t_old : t_in;
        hi_b = t_old < t_in ? t_in : t_old;
        if (t_new < lo_b) t_new = lo_b;
        if (t_new > hi_b) t_new = hi_b;
        node_t[i] = t_new[31:0];
      end
    end
    for (int j = 0; j < LINKS; j++) begin
      f = l_flow[j];
      q = f < 0 ? -f : f;
      up = (f >= 0) ? l_from[j] : l_to[j];
      vo = longint'(lv_old[j]);
      vn = longint'(lv_new[j]);
      t_old = snap_l[j];
      if (up < NODES) begin
        t_up = node_t[up];
        if (m_steady || (q != 0 && vn == 0)) begin
          link_t[j] = t_up[31:0];
        end else if (q == 0) begin
          link_t[j] = t_old[31:0];
        end else begin
          w = (q * dt) >>> 16;
          if (vn > vo) w += vn - vo;
          d = vo + w;
          while (d >= 64'sh8000_0000) begin
            vo = vo >>> 1;
            w = w >>> 1;
            d = vo + w;
          end
          if (d == 0) link_t[j] = t_up[31:0];
          else link_t[j] = clip32(t_old + ((t_up - t_old) * w) / d);
        end
      end
    end
  endfunction

  function automatic heat_result_t heat_predict(heat_word_t wd);
    heat_result_t r;
    logic node_ok;
    r.temp = '0;
    r.status = ST_OK;
    node_ok = wd.idx < NODES;
    case (wd.op)
      OP_LOAD_NODE: begin
        if (node_ok) begin
          nv_old[wd.idx] = wd.v_old;
          nv_in[wd.idx] = wd.v_in;
          n_rate[wd.idx] = wd.rate;
        end else r.status = ST_RANGE;
      end
      OP_LOAD_LINK: begin
        lv_old[wd.idx] = wd.v_old;
        lv_new[wd.idx] = wd.v_new;
        l_flow[wd.idx] = wd.flow;
        l_from[wd.idx] = wd.from_n;
        l_to[wd.idx] = wd.to_n;
      end
      OP_RUN: begin
        if (!m_enable || wd.dt == 0) r.status = ST_SKIP;
        else mix_step(wd.dt);
      end
      OP_READ_NODE: begin
        if (node_ok) r.temp = node_t[wd.idx]; else r.status = ST_RANGE;
      end
      OP_READ_LINK: r.temp = link_t[wd.idx];
      OP_WRITE_NODE: begin
        if (node_ok) node_t[wd.idx] = wd.temp; else r.status = ST_RANGE;
      end
      OP_WRITE_LINK: link_t[wd.idx] = wd.temp;
      default: r.status = ST_RANGE;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] pick_volume();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return $urandom_range(1, 2000 << 8);
    endcase
  endfunction

  function automatic logic signed [31:0] pick_signed(int unsigned span);
    case ($urandom_range(0, 11))
      0: return 32'sh0;
      1: return 32'sh7FFF_FFFF;
      2: return 32'sh8000_0000;
      3: return $urandom;
      default: return $signed($urandom_range(0, 2 * span)) - $signed(span);
    endcase
  endfunction

  function automatic logic [31:0] pick_dt();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return $urandom_range(1, 120 << 16);
    endcase
  endfunction

  function automatic heat_word_t make_word(logic [2:0] op, logic [4:0] idx);
    heat_word_t wd;
    wd.op = op;
    wd.idx = idx;
    wd.v_old = pick_volume();
    wd.v_in = pick_volume();
    wd.v_new = pick_volume();
    wd.rate = pick_signed(3000 << 8);
    wd.flow = pick_signed(80 << 8);
    wd.from_n = $urandom_range(0, 9) == 0 ? 5'($urandom_range(16, 31)) : 5'($urandom_range(0, 15));
    wd.to_n = $urandom_range(0, 9) == 0 ? 5'($urandom_range(16, 31)) : 5'($urandom_range(0, 15));
    wd.dt = pick_dt();
    wd.temp = pick_signed(90 << 16);
    return wd;
  endfunction

  function automatic void queue_word(logic [2:0] op, logic [4:0] idx);
    pending_words.push_back(make_word(op, idx));
  endfunction

  function automatic void queue_random_word();
    int unsigned sel;
    logic [4:0] nidx;
    sel = $urandom_range(0, 99);
    nidx = $urandom_range(0, 7) == 0 ? 5'($urandom_range(16, 31)) : 5'($urandom_range(0, 15));
    if (sel < 20) queue_word(OP_LOAD_NODE, nidx);
    else if (sel < 40) queue_word(OP_LOAD_LINK, 5'($urandom));
    else if (sel < 48) queue_word(OP_RUN, 5'($urandom));
    else if (sel < 63) queue_word(OP_READ_NODE, nidx);
    else if (sel < 82) queue_word(OP_READ_LINK, 5'($urandom));
    else if (sel < 89) queue_word(OP_WRITE_NODE, nidx);
    else if (sel < 97) queue_word(OP_WRITE_LINK, 5'($urandom));
    else queue_word(OP_UNUSED, 5'($urandom));
  endfunction

  // Input driver: bursts of words separated by random gaps.
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  always @(posedge clk_i) begin
    logic next_valid;
    next_valid = in_valid_i;
    if (in_valid_i && in_ready_o) begin
      expected_results.push_back(heat_predict(cur_word));
      next_valid = 1'b0;
    end
    if (rst_ni && !next_valid) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_words.size() > 0) begin
        cur_word = pending_words.pop_front();
        operation_i <= cur_word.op;
        index_i <= cur_word.idx;
        old_volume_i <= cur_word.v_old;
        inflow_volume_i <= cur_word.v_in;
        new_volume_i <= cur_word.v_new;
        external_rate_i <= cur_word.rate;
        flow_i <= cur_word.flow;
        from_node_i <= cur_word.from_n;
        to_node_i <= cur_word.to_n;
        time_step_i <= cur_word.dt;
        temperature_i <= cur_word.temp;
        next_valid = 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 24);
          gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
        end
      end
    end
    in_valid_i <= next_valid;
  end

  // Output monitor with a stall pattern whose mode is redrawn each time stall_cnt wraps.
  int unsigned stall_mode = 0;
  int unsigned stall_cnt = 0;
  always @(posedge clk_i) begin
    heat_result_t exp_r;
    if (out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result word temp=%h status=%0d", $realtime,
                 temperature_out_o, status_o);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (temperature_out_o !== exp_r.temp) begin
          $display("%0t: temperature_out mismatch expected %h actual %h", $realtime,
                   exp_r.temp, temperature_out_o);
          errors++;
        end
        if (status_o !== exp_r.status) begin
          $display("%0t: status mismatch expected %0d actual %0d", $realtime,
                   exp_r.status, status_o);
          errors++;
        end
      end
    end
    stall_cnt++;
    if (stall_cnt == 64) begin
      stall_cnt = 0;
      stall_mode = $urandom_range(0, 3);
    end
    out_ready_i <= rst_ni && ($urandom_range(0, 3) >= stall_mode);
  end

  // Watchdog on cycles without any accepted word.
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_network_heat_mixing_step: done, errors");
        $finish;
      end
    end
  end

  task automatic cfg_write(cfg_idx_e idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_ENABLE: m_enable = data[0];
      CFG_STEADY: m_steady = data[0];
      default:    m_init = data;
    endcase
  endtask

  task automatic wait_idle();
    while (pending_words.size() > 0)
      @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    while (expected_results.size() > 0 || in_valid_i)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    heat_word_t wd;
    m_enable = 0;
    m_steady = 0;
    m_init = 0;
    m_seeded = 0;
    foreach (node_t[i]) node_t[i] = 0;
    foreach (link_t[j]) link_t[j] = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Every node and link is loaded before any run can take effect.
    for (int i = 0; i < NODES; i++) begin
      wd = make_word(OP_LOAD_NODE, 5'(i));
      if (i == 0) begin wd.v_old = 0; wd.v_in = 0; wd.rate = 32'sh7FFF_FFFF; end
      if (i == 1) begin wd.v_old = 0; wd.v_in = 32'hFFFF_FFFF; wd.rate = 32'sh8000_0000; end
      if (i == 2) begin wd.v_old = 32'hFFFF_FFFF; wd.v_in = 1; end
      pending_words.push_back(wd);
    end
    for (int j = 0; j < LINKS; j++) begin
      wd = make_word(OP_LOAD_LINK, 5'(j));
      if (j == 0) begin wd.flow = 32'sh8000_0000; wd.v_new = 0; end
      if (j == 1) begin wd.flow = 32'sh7FFF_FFFF; wd.v_old = 32'hFFFF_FFFF; end
      if (j == 2) wd.flow = 0;
      if (j == 3) begin wd.from_n = 5'd31; wd.to_n = 5'd16; end
      if (j == 4) begin wd.v_old = 0; wd.v_new = 32'hFFFF_FFFF; end
      pending_words.push_back(wd);
    end
    // Disabled block: the run is skipped, bad indexes and the unused code fail.
    queue_word(OP_WRITE_NODE, 5'd3);
    queue_word(OP_WRITE_LINK, 5'd31);
    queue_word(OP_RUN, 5'd0);
    queue_word(OP_READ_NODE, 5'd3);
    queue_word(OP_READ_NODE, 5'd16);
    queue_word(OP_READ_NODE, 5'd31);
    queue_word(OP_WRITE_NODE, 5'd20);
    queue_word(OP_LOAD_NODE, 5'd31);
    queue_word(OP_READ_LINK, 5'd31);
    queue_word(OP_UNUSED, 5'd0);
    wait_idle();

    cfg_write(CFG_ENABLE, 32'h1);
    cfg_write(CFG_STEADY, 32'h0);
    cfg_write(CFG_INIT_TEMP, 32'h8000_0000);
    // A zero step is skipped; the first real run seeds over the earlier writes.
    wd = make_word(OP_RUN, 0);
    wd.dt = 0;
    pending_words.push_back(wd);
    wd.dt = 32'h0001_0000;
    pending_words.push_back(wd);
    queue_word(OP_READ_NODE, 5'd3);
    queue_word(OP_READ_LINK, 5'd31);
    wd.dt = 32'hFFFF_FFFF;
    pending_words.push_back(wd);
    queue_word(OP_READ_NODE, 5'd0);
    queue_word(OP_READ_NODE, 5'd1);
    queue_word(OP_READ_LINK, 5'd0);
    queue_word(OP_READ_LINK, 5'd1);
    wait_idle();
    cfg_write(CFG_INIT_TEMP, 32'h7FFF_FFFF);
    cfg_write(CFG_STEADY, 32'h1);

    for (int ph = 0; ph < 6; ph++) begin
      // Bring node temperatures back to moderate values before each phase.
      for (int i = 0; i < NODES; i++) begin
        wd = make_word(OP_WRITE_NODE, 5'(i));
        wd.temp = $signed($urandom_range(0, 180 << 16)) - $signed(90 << 16);
        pending_words.push_back(wd);
      end
      for (int n = 0; n < 125; n++) queue_random_word();
      wait_idle();
      cfg_write(CFG_ENABLE, ph == 3 ? 32'h0 : 32'h1);
      cfg_write(CFG_STEADY, 32'($urandom_range(0, 1)));
      cfg_write(CFG_INIT_TEMP, $urandom);
    end
    wait_idle();
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_network_heat_mixing_step: done, clean");
    end else begin
      $display("tb_network_heat_mixing_step: done, errors");
    end
    $finish;
  end

endmodule
